// ===== sv/gnos_pkg.sv =====
// Shared types and fixed-point constants of the gradient noise octave sum block.
package gnos_pkg;

	// Point coordinates are unsigned Q8.12
	localparam int COORD_W    = 20;
	localparam int FRAC_BITS  = 12;
	localparam int PREP_STEPS = COORD_W - FRAC_BITS;

	// Gradient components are signed Q1.14, three per table entry
	localparam int GRAD_W  = 16;
	localparam int ENTRY_W = 3 * GRAD_W;

	// Shared multiplier: signed 13-bit by signed 31-bit operands
	localparam int MUL_A_W = FRAC_BITS + 1;
	localparam int MUL_B_W = 31;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Corner dot products and blended values, signed Q.26
	localparam int DOT_W = 30;

	// Weighted octave accumulator
	localparam int ACC_W    = 64;
	localparam int SUM_SHIFT = 30;
	localparam int WEIGHT_LOG2 = 16;

	// Output fields
	localparam int NOISE_W = 16;
	localparam int LEVEL_W = 4;

	// Opcodes of the command beat
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	// Control from the sequencer to the lattice tracker
	typedef struct packed {
		logic load;
		logic step;
	} lat_ctl_t;

endpackage

// ===== sv/gnos_lattice.sv =====
// Lattice tracker: coordinate fractions, cell residues and gradient table address.
module gnos_lattice #(
	parameter int GRID_SIZE = 64,
	localparam int AW = $clog2(GRID_SIZE * GRID_SIZE)
) (
	input  logic                                clk,
	input  gnos_pkg::lat_ctl_t                  ctl,
	input  logic [gnos_pkg::COORD_W-1:0]        point_x,
	input  logic [gnos_pkg::COORD_W-1:0]        point_y,
	input  logic [gnos_pkg::COORD_W-1:0]        point_z,
	input  logic [2:0]                          corner,
	output logic [gnos_pkg::FRAC_BITS-1:0]      t_x,
	output logic [gnos_pkg::FRAC_BITS-1:0]      t_y,
	output logic [gnos_pkg::FRAC_BITS-1:0]      t_z,
	output logic [AW-1:0]                       rd_addr
);

	localparam int RW = $clog2(GRID_SIZE);
	localparam logic [RW:0]   GR  = (RW + 1)'(GRID_SIZE);
	localparam logic [RW+1:0] G1  = (RW + 2)'(GRID_SIZE);
	localparam logic [RW+1:0] G2  = (RW + 2)'(2 * GRID_SIZE);
	localparam logic [AW-1:0] GA  = AW'(GRID_SIZE);
	localparam int CW = gnos_pkg::COORD_W;
	localparam int FB = gnos_pkg::FRAC_BITS;

	logic [CW-1:0] sx_q, sy_q, sz_q;
	logic [RW-1:0] rx_q, ry_q, rz_q;
	logic [RW-1:0] row, col;

	// Shift one more integer bit into a residue modulo the grid size
	function automatic logic [RW-1:0] shift_in(input logic [RW-1:0] r, input logic b);
		logic [RW:0] v;
		v = {r, b};
		if (v >= GR)
			v = v - GR;
		return v[RW-1:0];
	endfunction

	// Sum two residues and two corner bits, modulo the grid size
	function automatic logic [RW-1:0] wrap_sum(input logic [RW-1:0] a, input logic [RW-1:0] b,
			input logic da, input logic db);
		logic [RW+1:0] s;
		s = (RW + 2)'(a) + (RW + 2)'(b) + (RW + 2)'(da) + (RW + 2)'(db);
		if (s >= G2)
			s = s - G2;
		else if (s >= G1)
			s = s - G1;
		return s[RW-1:0];
	endfunction

	// Load the point, then move one bit from fraction to integer part per step
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sx_q <= point_x;
			sy_q <= point_y;
			sz_q <= point_z;
			rx_q <= '0;
			ry_q <= '0;
			rz_q <= '0;
		end else if (ctl.step) begin
			sx_q <= {sx_q[CW-2:0], 1'b0};
			sy_q <= {sy_q[CW-2:0], 1'b0};
			sz_q <= {sz_q[CW-2:0], 1'b0};
			rx_q <= shift_in(rx_q, sx_q[CW-1]);
			ry_q <= shift_in(ry_q, sy_q[CW-1]);
			rz_q <= shift_in(rz_q, sz_q[CW-1]);
		end
	end

	assign t_x = sx_q[CW-1 -: FB];
	assign t_y = sy_q[CW-1 -: FB];
	assign t_z = sz_q[CW-1 -: FB];

	// Table row from x and z, column from y and z
	assign row     = wrap_sum(rx_q, rz_q, corner[0], corner[2]);
	assign col     = wrap_sum(ry_q, rz_q, corner[1], corner[2]);
	assign rd_addr = AW'(row) * GA + AW'(col);

endmodule

// ===== sv/gradient_noise_octave_sum_top.sv =====
// Top level: gradient table, shared multiplier and the octave sequencer.
// A write beat returns nothing. An evaluate beat runs the prep steps, then per
// octave the corner products, blends and weighting, then a final step; the
// result is then registered on noise_sum and level, done is high for one
// cycle, and busy drops in that same cycle. The run is paced by the
// single multiplier, which does three products per lattice corner and one
// per blend and octave weight, and by the one read port of the gradient
// table. done cannot be held off: capture the result in the cycle it shows.
module gradient_noise_octave_sum_top #(
	parameter int GRID_SIZE = 64,
	parameter int OCTAVES   = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 opcode,
	input  logic [11:0]                          entry_index,
	input  logic signed [gnos_pkg::GRAD_W-1:0]   grad_x,
	input  logic signed [gnos_pkg::GRAD_W-1:0]   grad_y,
	input  logic signed [gnos_pkg::GRAD_W-1:0]   grad_z,
	input  logic [gnos_pkg::COORD_W-1:0]         point_x,
	input  logic [gnos_pkg::COORD_W-1:0]         point_y,
	input  logic [gnos_pkg::COORD_W-1:0]         point_z,
	output logic                                 done,
	output logic signed [gnos_pkg::NOISE_W-1:0]  noise_sum,
	output logic [gnos_pkg::LEVEL_W-1:0]         level
);

	localparam int AW    = $clog2(GRID_SIZE * GRID_SIZE);
	localparam int DEPTH = GRID_SIZE * GRID_SIZE;
	localparam int FB    = gnos_pkg::FRAC_BITS;
	localparam int GW    = gnos_pkg::GRAD_W;
	localparam int DW    = gnos_pkg::DOT_W;
	localparam int AC    = gnos_pkg::ACC_W;

	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_FETCH, S_MX, S_MY, S_MZ, S_ACC,
		S_LD, S_LM, S_LA, S_WM, S_WA, S_ADV, S_FIN
	} state_t;

	state_t state_q;

	logic [gnos_pkg::ENTRY_W-1:0] mem [DEPTH];
	logic [gnos_pkg::ENTRY_W-1:0] rd_q;
	logic [AW-1:0]                rd_addr;
	logic                         wr_en;

	gnos_pkg::lat_ctl_t lat_ctl;
	logic [FB-1:0] t_x, t_y, t_z, t_sel;

	logic [2:0] cnt_q;
	logic [2:0] c_q;
	logic [2:0] o_q;
	logic [2:0] l_q;
	logic [3:0] n_q;
	logic [11:0] pow3_q;

	logic signed [gnos_pkg::MUL_A_W-1:0] mul_a;
	logic signed [gnos_pkg::MUL_B_W-1:0] mul_b;
	logic signed [gnos_pkg::PROD_W-1:0]  prod_q;
	logic signed [DW-1:0]                dot_q;
	logic signed [gnos_pkg::MUL_B_W-1:0] diff_q;
	logic signed [DW-1:0]                k_q [8];
	logic signed [AC-1:0]                acc_q;

	logic signed [DW-1:0]      lerp_res;
	logic [4:0]                wsh;
	logic signed [AC-1:0]      sum_full;
	logic signed [gnos_pkg::NOISE_W-1:0] sum_sat;
	logic signed [gnos_pkg::NOISE_W:0]   lv;
	logic [gnos_pkg::LEVEL_W-1:0]        lv_clamp;

	assign busy = (state_q != S_IDLE);

	// Write the gradient table on a write beat that lands inside the grid
	assign wr_en = (state_q == S_IDLE) && start && (opcode == gnos_pkg::OP_WRITE)
		&& (32'(entry_index) < DEPTH);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[AW'(entry_index)] <= {grad_z, grad_y, grad_x};
		rd_q <= mem[rd_addr];
	end

	// Lattice tracker: load on an evaluate beat, step during prep and octave advance
	assign lat_ctl.load = (state_q == S_IDLE) && start && (opcode == gnos_pkg::OP_EVAL);
	assign lat_ctl.step = (state_q == S_PREP) || (state_q == S_ADV);

	gnos_lattice #(.GRID_SIZE(GRID_SIZE)) u_lattice (
		.clk     (clk),
		.ctl     (lat_ctl),
		.point_x (point_x),
		.point_y (point_y),
		.point_z (point_z),
		.corner  (c_q),
		.t_x     (t_x),
		.t_y     (t_y),
		.t_z     (t_z),
		.rd_addr (rd_addr)
	);

	// Pick the blend fraction: four x blends, two y blends, one z blend
	always_comb begin
		if (l_q < 3'd4)
			t_sel = t_x;
		else if (l_q < 3'd6)
			t_sel = t_y;
		else
			t_sel = t_z;
	end

	// Route operands to the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MX: begin
				mul_a = $signed({c_q[0], t_x});
				mul_b = gnos_pkg::MUL_B_W'($signed(rd_q[GW-1:0]));
			end
			S_MY: begin
				mul_a = $signed({c_q[1], t_y});
				mul_b = gnos_pkg::MUL_B_W'($signed(rd_q[2*GW-1:GW]));
			end
			S_MZ: begin
				mul_a = $signed({c_q[2], t_z});
				mul_b = gnos_pkg::MUL_B_W'($signed(rd_q[3*GW-1:2*GW]));
			end
			S_LM: begin
				mul_a = $signed({1'b0, t_sel});
				mul_b = diff_q;
			end
			S_WM: begin
				mul_a = $signed({1'b0, pow3_q});
				mul_b = gnos_pkg::MUL_B_W'(k_q[0]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Blend result, octave weight shift, final scaling and level
	assign lerp_res = k_q[0] + DW'(prod_q >>> FB);
	assign wsh      = 5'(gnos_pkg::WEIGHT_LOG2) - {o_q, 1'b0};
	assign sum_full = acc_q >>> gnos_pkg::SUM_SHIFT;

	always_comb begin
		if (sum_full > 64'sd32767)
			sum_sat = 16'sh7FFF;
		else if (sum_full < -64'sd32768)
			sum_sat = 16'sh8000;
		else
			sum_sat = gnos_pkg::NOISE_W'(sum_full);
		lv = (gnos_pkg::NOISE_W + 1)'(sum_sat) + 17'sd4096;
		if (lv < 0)
			lv_clamp = '0;
		else if ((lv >>> 10) > 17'sd15)
			lv_clamp = 4'd15;
		else
			lv_clamp = gnos_pkg::LEVEL_W'(lv >>> 10);
	end

	// Sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
			cnt_q   <= '0;
			c_q     <= '0;
			o_q     <= '0;
			l_q     <= '0;
			n_q     <= '0;
			pow3_q  <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start && (opcode == gnos_pkg::OP_EVAL)) begin
						cnt_q   <= '0;
						o_q     <= '0;
						pow3_q  <= 12'd1;
						acc_q   <= '0;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'(gnos_pkg::PREP_STEPS - 1)) begin
						c_q     <= '0;
						state_q <= S_FETCH;
					end
				end
				S_FETCH: state_q <= S_MX;
				S_MX:    state_q <= S_MY;
				S_MY: begin
					dot_q   <= DW'(prod_q);
					state_q <= S_MZ;
				end
				S_MZ: begin
					dot_q   <= dot_q + DW'(prod_q);
					c_q     <= c_q + 3'd1;
					state_q <= S_ACC;
				end
				S_ACC: begin
					// Store the finished corner; the next corner's read lands meanwhile
					k_q[c_q - 3'd1] <= dot_q + DW'(prod_q);
					if (c_q == 3'd0) begin
						n_q     <= 4'd8;
						l_q     <= '0;
						state_q <= S_LD;
					end else begin
						state_q <= S_MX;
					end
				end
				S_LD: begin
					diff_q  <= gnos_pkg::MUL_B_W'(k_q[1]) - gnos_pkg::MUL_B_W'(k_q[0]);
					state_q <= S_LM;
				end
				S_LM: state_q <= S_LA;
				S_LA: begin
					// Drop the two blended values and append the result
					for (int i = 0; i < 8; i++) begin
						if (4'(i) == n_q - 4'd2)
							k_q[i] <= lerp_res;
						else if (i < 6)
							k_q[i] <= k_q[3'(i + 2)];
					end
					n_q <= n_q - 4'd1;
					l_q <= l_q + 3'd1;
					if (l_q == 3'd6)
						state_q <= S_WM;
					else
						state_q <= S_LD;
				end
				S_WM: state_q <= S_WA;
				S_WA: begin
					acc_q   <= acc_q + (AC'(prod_q) <<< wsh);
					state_q <= S_ADV;
				end
				S_ADV: begin
					o_q    <= o_q + 3'd1;
					pow3_q <= pow3_q + {pow3_q[10:0], 1'b0};
					c_q    <= '0;
					if (o_q == 3'(OCTAVES - 1))
						state_q <= S_FIN;
					else
						state_q <= S_FETCH;
				end
				S_FIN: begin
					noise_sum <= sum_sat;
					level     <= lv_clamp;
					done      <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== dv/gradient_noise_octave_sum_top_tb.sv =====
// Self-checking testbench for the four-octave gradient noise sum block.
module gradient_noise_octave_sum_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID        = 64;
	localparam int OCT         = 4;
	localparam int ENTRIES     = GRID * GRID;
	localparam int IDLE_LIMIT  = 2000;
	localparam int TOTAL_BEATS = 1600;

	typedef struct {
		logic                               op;
		logic [11:0]                        idx;
		logic signed [gnos_pkg::GRAD_W-1:0] gx, gy, gz;
		logic [gnos_pkg::COORD_W-1:0]       px, py, pz;
	} beat_t;

	typedef struct {
		logic signed [gnos_pkg::NOISE_W-1:0] noise;
		logic [gnos_pkg::LEVEL_W-1:0]        lvl;
	} noise_res_t;

	logic clk, arst_n, start, busy, opcode, done;
	logic [11:0] entry_index;
	logic signed [gnos_pkg::GRAD_W-1:0] grad_x, grad_y, grad_z;
	logic [gnos_pkg::COORD_W-1:0] point_x, point_y, point_z;
	logic signed [gnos_pkg::NOISE_W-1:0] noise_sum;
	logic [gnos_pkg::LEVEL_W-1:0] level;

	// Predictor state: own copy of the gradient table
	logic signed [gnos_pkg::GRAD_W-1:0] grad_tab [ENTRIES][3];
	noise_res_t expected_noise [$];
	int fails;
	int idle_cycles;
	int items_sent;

	// Write marks: zero means never written, else the fill pass that wrote it
	int wr_mark [ENTRIES];
	int pass_id;
	bit fill_fixed;
	int fill_gx, fill_gy, fill_gz;

	gradient_noise_octave_sum_top dut (.*);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Blend two Q.26 values by a Q0.12 fraction, rounding toward minus infinity
	function automatic longint blend(longint a, longint b, longint t);
		return a + ((t * (b - a)) >>> gnos_pkg::FRAC_BITS);
	endfunction

	// Noise of one octave at an already scaled point
	function automatic longint octave_value(longint sx, longint sy, longint sz);
		longint ix, iy, iz, tx, ty, tz, vx, vy, vz, e0, e1, e2, e3;
		longint corner [8];
		int row, col;
		ix = sx >> gnos_pkg::FRAC_BITS;
		iy = sy >> gnos_pkg::FRAC_BITS;
		iz = sz >> gnos_pkg::FRAC_BITS;
		tx = sx & 12'hFFF;
		ty = sy & 12'hFFF;
		tz = sz & 12'hFFF;
		for (int c = 0; c < 8; c++) begin
			row = (ix + c[0] + iz + c[2]) % GRID;
			col = (iy + c[1] + iz + c[2]) % GRID;
			vx = tx - c[0] * 4096;
			vy = ty - c[1] * 4096;
			vz = tz - c[2] * 4096;
			corner[c] = vx * grad_tab[row*GRID+col][0] + vy * grad_tab[row*GRID+col][1]
				+ vz * grad_tab[row*GRID+col][2];
		end
		e0 = blend(corner[0], corner[1], tx);
		e1 = blend(corner[2], corner[3], tx);
		e2 = blend(corner[4], corner[5], tx);
		e3 = blend(corner[6], corner[7], tx);
		return blend(blend(e0, e1, ty), blend(e2, e3, ty), tz);
	endfunction

	// Weighted octave sum, saturated, and its level
	function automatic noise_res_t octave_sum(beat_t b);
		noise_res_t r;
		longint acc, s, lv, pow3;
		acc = 0;
		pow3 = 1;
		for (int o = 0; o < OCT; o++) begin
			acc += octave_value(longint'(b.px) << o, longint'(b.py) << o,
				longint'(b.pz) << o) * (pow3 << (gnos_pkg::WEIGHT_LOG2 - 2*o));
			pow3 *= 3;
		end
		s = acc >>> gnos_pkg::SUM_SHIFT;
		if (s > 32767) s = 32767;
		if (s < -32768) s = -32768;
		lv = s + 4096;
		if (lv < 0) lv = 0;
		else lv = lv >> 10;
		if (lv > 15) lv = 15;
		r.noise = s[15:0];
		r.lvl = lv[3:0];
		return r;
	endfunction

	// Table entry read by one corner of one octave
	function automatic int table_index(int px, int py, int pz, int o, int c);
		int ix, iy, iz, dx, dy, dz;
		ix = (px << o) >> gnos_pkg::FRAC_BITS;
		iy = (py << o) >> gnos_pkg::FRAC_BITS;
		iz = (pz << o) >> gnos_pkg::FRAC_BITS;
		dx = c & 1;
		dy = (c >> 1) & 1;
		dz = (c >> 2) & 1;
		return ((ix + dx + iz + dz) % GRID) * GRID + (iy + dy + iz + dz) % GRID;
	endfunction

	// Send one beat after a gap; start stays high for a back-to-back follower
	task automatic send_beat(beat_t b, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= b.op;
		entry_index <= b.idx;
		grad_x <= b.gx;
		grad_y <= b.gy;
		grad_z <= b.gz;
		point_x <= b.px;
		point_y <= b.py;
		point_z <= b.pz;
		do @(posedge clk); while (busy);
		// accepted: advance the predictor
		items_sent++;
		if (b.op == gnos_pkg::OP_WRITE) begin
			grad_tab[b.idx][0] = b.gx;
			grad_tab[b.idx][1] = b.gy;
			grad_tab[b.idx][2] = b.gz;
			wr_mark[b.idx] = pass_id;
		end else begin
			expected_noise.push_back(octave_sum(b));
		end
	endtask

	function automatic beat_t write_beat(int idx, int gx, int gy, int gz);
		beat_t b;
		b.op = gnos_pkg::OP_WRITE;
		b.idx = 12'(idx);
		b.gx = gnos_pkg::GRAD_W'(gx);
		b.gy = gnos_pkg::GRAD_W'(gy);
		b.gz = gnos_pkg::GRAD_W'(gz);
		b.px = gnos_pkg::COORD_W'($urandom);
		b.py = gnos_pkg::COORD_W'($urandom);
		b.pz = gnos_pkg::COORD_W'($urandom);
		return b;
	endfunction

	function automatic beat_t eval_beat(int px, int py, int pz);
		beat_t b;
		b.op = gnos_pkg::OP_EVAL;
		b.idx = 12'($urandom);
		b.gx = gnos_pkg::GRAD_W'($urandom);
		b.gy = gnos_pkg::GRAD_W'($urandom);
		b.gz = gnos_pkg::GRAD_W'($urandom);
		b.px = gnos_pkg::COORD_W'(px);
		b.py = gnos_pkg::COORD_W'(py);
		b.pz = gnos_pkg::COORD_W'(pz);
		return b;
	endfunction

	function automatic int rand_grad();
		// mostly unit-range components, some full 16-bit values
		if ($urandom_range(0, 3) == 0) return $urandom_range(0, 65535) - 32768;
		return $urandom_range(0, 32768) - 16384;
	endfunction

	function automatic int rand_gap();
		// stretches without idling as well as random gaps
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 7);
	endfunction

	// Hold the sender until every expected result has arrived
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (expected_noise.size() != 0);
	endtask

	// Write every entry a point reads: the fixed vector in a fixed pass, else
	// random vectors into entries that were never written
	task automatic cover_point(int px, int py, int pz);
		int idx;
		for (int o = 0; o < OCT; o++) begin
			for (int c = 0; c < 8; c++) begin
				idx = table_index(px, py, pz, o, c);
				if (fill_fixed && wr_mark[idx] != pass_id)
					send_beat(write_beat(idx, fill_gx, fill_gy, fill_gz), rand_gap());
				else if (wr_mark[idx] == 0)
					send_beat(write_beat(idx, rand_grad(), rand_grad(), rand_grad()),
						rand_gap());
			end
		end
	endtask

	// Evaluate one point once its table entries are written
	task automatic eval_point(int px, int py, int pz, int gap);
		cover_point(px, py, pz);
		send_beat(eval_beat(px, py, pz), gap);
	endtask

	// Points at the coordinate extremes and fraction edges
	task automatic test_point_extremes();
		eval_point(0, 0, 0, 0);
		eval_point(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 0);
		eval_point(20'h00800, 20'h00800, 20'h00800, 3);
		eval_point(20'hFFFFF, 0, 20'h00FFF, 0);
		eval_point(20'h00FFF, 20'h01000, 0, 1);
	endtask

	// One saturation pass with every read entry set to one vector
	task automatic saturate_with(int gx, int gy, int gz, bit center);
		pass_id++;
		fill_fixed = 1'b1;
		fill_gx = gx;
		fill_gy = gy;
		fill_gz = gz;
		test_point_extremes();
		if (center)
			eval_point(20'h00C00, 20'h00C00, 20'h00C00, 0);
		drain();
		fill_fixed = 1'b0;
	endtask

	// Saturation: read entries full of extreme gradients
	task automatic test_saturation();
		saturate_with(32767, 32767, 32767, 1'b1);
		saturate_with(-32768, -32768, -32768, 1'b1);
		saturate_with(16384, -16384, 16384, 1'b0);
		pass_id++;
	endtask

	// Random mix of writes and evaluations over written entries
	task automatic test_random();
		int px, py, pz;
		bit drained;
		drained = 1'b0;
		while (items_sent < TOTAL_BEATS) begin
			if ($urandom_range(0, 1) == 0) begin
				send_beat(write_beat($urandom_range(0, ENTRIES-1), rand_grad(), rand_grad(),
					rand_grad()), rand_gap());
			end else begin
				px = $urandom_range(0, 20'hFFFFF);
				py = $urandom_range(0, 20'hFFFFF);
				pz = $urandom_range(0, 20'hFFFFF);
				if ($urandom_range(0, 1) == 0) begin
					px = px & 20'h3FFF;
					py = py & 20'h3FFF;
					pz = pz & 20'h3FFF;
				end
				eval_point(px, py, pz, rand_gap());
			end
			if (!drained && items_sent >= TOTAL_BEATS / 2) begin
				drain();
				drained = 1'b1;
			end
		end
	endtask

	// Compare each result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_noise.size() == 0) begin
				$error("unexpected result noise_sum=%0d level=%0d", noise_sum, level);
				fails++;
			end else begin
				if (noise_sum !== expected_noise[0].noise) begin
					$error("noise_sum: expected %0d, actual %0d",
						expected_noise[0].noise, noise_sum);
					fails++;
				end
				if (level !== expected_noise[0].lvl) begin
					$error("level: expected %0d, actual %0d", expected_noise[0].lvl, level);
					fails++;
				end
				void'(expected_noise.pop_front());
			end
		end
	end

	// Watchdog on cycles with no beat accepted and no result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("gradient_noise_octave_sum_top_tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		fails = 0;
		idle_cycles = 0;
		items_sent = 0;
		pass_id = 1;
		fill_fixed = 1'b0;
		fill_gx = 0;
		fill_gy = 0;
		fill_gz = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		opcode <= gnos_pkg::OP_WRITE;
		entry_index <= '0;
		grad_x <= '0;
		grad_y <= '0;
		grad_z <= '0;
		point_x <= '0;
		point_y <= '0;
		point_z <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_saturation();
		test_random();
		drain();
		repeat (20) @(posedge clk);
		if (fails == 0 && expected_noise.size() == 0)
			$display("gradient_noise_octave_sum_top_tb: PASS");
		else
			$display("gradient_noise_octave_sum_top_tb: FAIL");
		$finish;
	end

endmodule
